FILE: rtl/wss_pkg.sv
package wss_pkg;

  // Fixed field widths
  localparam int unsigned WIN_W  = 17;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_HAY    = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND      = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_BAD_WINDOW = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START  = 2'd0,
    CFG_WIN_END    = 2'd1,
    CFG_END_IS_LEN = 2'd2
  } cfg_idx_e;

  // Per-cycle control broadcast to every cell of the row
  typedef struct packed {
    logic hay_shift;  // shift a haystack byte into the recent-byte chain
    logic ndl_shift;  // shift a needle byte into the reversed needle chain
    logic ndl_clear;  // drop all needle bytes
  } cell_ctrl_t;

endpackage

FILE: rtl/wss_in_if.sv
interface wss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output operation, output data_byte, output last,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input last,
                output ready);
endinterface

FILE: rtl/wss_out_if.sv
interface wss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] match_position;

  modport source (output valid, output status, output match_position, input ready);
  modport sink (input valid, input status, input match_position, output ready);
endinterface

FILE: rtl/wss_cell.sv
module wss_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wss_pkg::cell_ctrl_t    ctrl_i,
  input  logic [7:0]             hay_byte_i,
  input  logic [7:0]             ndl_byte_i,
  input  logic                   ndl_used_i,
  output logic [7:0]             hay_byte_o,
  output logic [7:0]             ndl_byte_o,
  output logic                   ndl_used_o,
  output logic                   hit_o
);
  import wss_pkg::*;

  logic [BYTE_W-1:0] hay_q, ndl_q;
  logic              used_q;

  // Payload chains: haystack bytes and reversed needle bytes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.hay_shift) begin
      hay_q <= hay_byte_i;
    end
    if (ctrl_i.ndl_shift) begin
      ndl_q <= ndl_byte_i;
    end
  end

  // Marks cells that hold a needle byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (ctrl_i.ndl_clear) begin
      used_q <= 1'b0;
    end else if (ctrl_i.ndl_shift) begin
      used_q <= ndl_used_i;
    end
  end

  // Compare against the byte entering this cell now
  assign hit_o      = !used_q || (hay_byte_i == ndl_q);
  assign hay_byte_o = hay_q;
  assign ndl_byte_o = ndl_q;
  assign ndl_used_o = used_q;

endmodule

FILE: rtl/wss_row.sv
module wss_row #(
  parameter int unsigned NEEDLE_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wss_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  output logic                hit_o
);
  import wss_pkg::*;

  logic [BYTE_W-1:0] hay_chain [NEEDLE_MAX+1];
  logic [BYTE_W-1:0] ndl_chain [NEEDLE_MAX+1];
  logic [NEEDLE_MAX:0]   used_chain;
  logic [NEEDLE_MAX-1:0] hits;

  // Head of both chains is the incoming word's byte
  assign hay_chain[0]  = byte_i;
  assign ndl_chain[0]  = byte_i;
  assign used_chain[0] = 1'b1;

  for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
    wss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .hay_byte_i (hay_chain[k]),
      .ndl_byte_i (ndl_chain[k]),
      .ndl_used_i (used_chain[k]),
      .hay_byte_o (hay_chain[k+1]),
      .ndl_byte_o (ndl_chain[k+1]),
      .ndl_used_o (used_chain[k+1]),
      .hit_o      (hits[k])
    );
  end

  // Needle ends at the incoming byte when every used cell agrees
  assign hit_o = &hits;

endmodule

FILE: rtl/windowed_substring_search_core.sv
// Windowed substring search.
// in_i carries words of {operation, data_byte, last}: clear needle, append a
// needle byte, or one haystack byte. out_o gives one word {status,
// match_position} for each haystack byte marked last, nothing for others.
// Configuration (window start, window end, end-is-length) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while the block is idle;
// the block does not enforce it. A new input word may follow each cycle while
// in_i.ready is high. The needle sits in a row of NEEDLE_MAX cells next to
// the last NEEDLE_MAX haystack bytes; all cells compare in the cycle the byte
// arrives, so the result is registered, valid the cycle after the last byte.
// in_i.ready is high while the result register is empty or being drained;
// when the receiver stalls with a result pending, input stops until taken.
// Reset empties the needle, the haystack count and the result register and
// loads window start 0, window end 0, end-is-length 1.
module windowed_substring_search_core #(
  parameter int unsigned NEEDLE_MAX   = 16,
  parameter int unsigned HAYSTACK_MAX = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wss_in_if.sink       in_i,
  wss_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);
  import wss_pkg::*;

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned CNT_W = $clog2(HAYSTACK_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  // Configuration registers
  logic [WIN_W-1:0] win_start_q, win_end_q;
  logic             end_is_len_q;

  // Needle and haystack state
  logic [LEN_W-1:0] ndl_len_q, ndl_len_d;
  logic             ndl_ovf_q, ndl_ovf_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             hay_ovf_q, hay_ovf_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] fpos_q, fpos_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic       in_fire, hay_fire, hay_take, cnt_full, ndl_full, row_hit, check;
  logic       bad, load;
  cell_ctrl_t ctrl;
  logic [CNT_W-1:0] count_inc;
  logic [CMP_W-1:0] size_c, p_c, start_c, end_c, pend_c, len_c;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign ndl_full   = (ndl_len_q == LEN_W'(NEEDLE_MAX));
  assign cnt_full   = (count_q >= CNT_W'(HAYSTACK_MAX));
  assign hay_fire   = in_fire && (in_i.operation == OP_HAY);
  assign hay_take   = hay_fire && !cnt_full;

  // Control for the cell row
  assign ctrl.hay_shift = hay_take;
  assign ctrl.ndl_shift = in_fire && (in_i.operation == OP_APPEND) && !ndl_full;
  assign ctrl.ndl_clear = in_fire && (in_i.operation == OP_CLEAR);

  wss_row #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .byte_i (in_i.data_byte),
    .hit_o  (row_hit)
  );

  // Candidate start position of a match ending at this byte
  assign count_inc = count_q + CNT_W'(1);
  assign len_c     = CMP_W'(ndl_len_q);
  assign start_c   = CMP_W'(win_start_q);
  assign end_c     = CMP_W'(win_end_q);
  assign p_c       = CMP_W'(count_inc) - len_c;
  assign check = hay_take && !found_q && (ndl_len_q != '0) &&
                 (CMP_W'(count_inc) >= len_c) && (p_c >= start_c) &&
                 (end_is_len_q || (p_c < end_c)) && row_hit;

  // Final-word window checks
  assign size_c = hay_take ? CMP_W'(count_inc) : CMP_W'(count_q);
  assign pend_c = end_is_len_q ? size_c : end_c;
  assign bad    = (start_c > size_c) ||
                  (!end_is_len_q && ((end_c > size_c) || (end_c < start_c)));
  assign load   = hay_fire && in_i.last;

  // Next state
  always_comb begin
    ndl_len_d   = ndl_len_q;
    ndl_ovf_d   = ndl_ovf_q;
    count_d     = count_q;
    hay_ovf_d   = hay_ovf_q;
    found_d     = found_q;
    fpos_d      = fpos_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    pos_d       = pos_q;

    if (ctrl.ndl_clear) begin
      ndl_len_d = '0;
      ndl_ovf_d = 1'b0;
    end
    if (in_fire && (in_i.operation == OP_APPEND)) begin
      if (ndl_full) begin
        ndl_ovf_d = 1'b1;
      end else begin
        ndl_len_d = ndl_len_q + LEN_W'(1);
      end
    end
    if (hay_fire) begin
      if (cnt_full) begin
        hay_ovf_d = 1'b1;
      end else begin
        count_d = count_inc;
      end
      if (check) begin
        found_d = 1'b1;
        fpos_d  = p_c[POS_W-1:0];
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = '0;
      if (ndl_ovf_q || hay_ovf_d) begin
        status_d = ST_OVERFLOW;
      end else if (bad) begin
        status_d = ST_BAD_WINDOW;
      end else if (ndl_len_q == '0) begin
        if (start_c < pend_c) begin
          status_d = ST_FOUND;
          pos_d    = win_start_q[POS_W-1:0];
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end else if (found_d) begin
        status_d = ST_FOUND;
        pos_d    = fpos_d;
      end else begin
        status_d = ST_NOT_FOUND;
      end
      // Rearm for the next haystack
      count_d   = '0;
      hay_ovf_d = 1'b0;
      found_d   = 1'b0;
      fpos_d    = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndl_len_q   <= '0;
      ndl_ovf_q   <= 1'b0;
      count_q     <= '0;
      hay_ovf_q   <= 1'b0;
      found_q     <= 1'b0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ndl_len_q   <= ndl_len_d;
      ndl_ovf_q   <= ndl_ovf_d;
      count_q     <= count_d;
      hay_ovf_q   <= hay_ovf_d;
      found_q     <= found_d;
      fpos_q      <= fpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q  <= '0;
      win_end_q    <= '0;
      end_is_len_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN_START:  win_start_q  <= cfg_data_i;
        CFG_WIN_END:    win_end_q    <= cfg_data_i;
        CFG_END_IS_LEN: end_is_len_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.match_position = pos_q;

  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndl_len_q <= LEN_W'(NEEDLE_MAX))
    else $error("needle length beyond capacity");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HAYSTACK_MAX))
    else $error("haystack count beyond capacity");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_FOUND)) |-> (pos_q == '0))
    else $error("position nonzero without a match");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (count_q == '0) && !found_q))
    else $error("last byte did not produce a result and rearm");

endmodule
